// ===== sv/stwmwv_pkg.sv =====
`default_nettype none
package stwmwv_pkg;

	// field widths
	localparam int unsigned WORD_W = 9;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CHAR_W = 8;

	// seatalk command codes
	localparam logic [BYTE_W-1:0] CMD_ANGLE = 8'h10;
	localparam logic [BYTE_W-1:0] CMD_SPEED = 8'h11;
	localparam logic [BYTE_W-1:0] SPEED_MASK = 8'h7F;

	// binary to bcd converter: 15-bit values, five decimal digits
	localparam int unsigned BIN_W = 15;
	localparam int unsigned ANG_DIGITS = 5;
	localparam int unsigned SPD_DIGITS = 4;
	localparam int unsigned CNT_W = $clog2(BIN_W + 1);

	// microprogram size
	localparam int unsigned UC_LEN = 39;
	localparam int unsigned STEP_W = $clog2(UC_LEN);

	// word position in a datagram
	typedef enum logic [1:0] {
		POS_IDLE  = 2'd0,
		POS_BYTE1 = 2'd1,
		POS_BYTE2 = 2'd2,
		POS_BYTE3 = 2'd3
	} pos_t;

	// microcode operations
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_CONV,
		OP_CONST,
		OP_ANG,
		OP_SPD,
		OP_SUM_HI,
		OP_SUM_LO
	} op_t;

	// one control word
	typedef struct packed {
		op_t              op;
		logic [CHAR_W-1:0] arg;     // character or digit index
		logic             sum_en;  // fold into the checksum
		logic             lead;    // digit dropped while still a leading zero
		logic             last;    // final character of a sentence
	} ucw_t;

	function automatic ucw_t mk(input op_t op, input logic [CHAR_W-1:0] arg,
		input logic sum_en, input logic lead, input logic last);
		ucw_t w;
		w.op = op;
		w.arg = arg;
		w.sum_en = sum_en;
		w.lead = lead;
		w.last = last;
		return w;
	endfunction

	// sentence program: $WIMWV,<angle>,R,<speed>,N,A*<sum><CR><LF> CR LF
	function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
		ucw_t w;
		unique case (step)
			6'd0:  w = mk(OP_IDLE,   8'h00, 1'b0, 1'b0, 1'b0);
			6'd1:  w = mk(OP_CONV,   8'h00, 1'b0, 1'b0, 1'b0);
			6'd2:  w = mk(OP_CONST,  "$",   1'b0, 1'b0, 1'b0);
			6'd3:  w = mk(OP_CONST,  "W",   1'b1, 1'b0, 1'b0);
			6'd4:  w = mk(OP_CONST,  "I",   1'b1, 1'b0, 1'b0);
			6'd5:  w = mk(OP_CONST,  "M",   1'b1, 1'b0, 1'b0);
			6'd6:  w = mk(OP_CONST,  "W",   1'b1, 1'b0, 1'b0);
			6'd7:  w = mk(OP_CONST,  "V",   1'b1, 1'b0, 1'b0);
			6'd8:  w = mk(OP_CONST,  ",",   1'b1, 1'b0, 1'b0);
			6'd9:  w = mk(OP_ANG,    8'd4,  1'b1, 1'b1, 1'b0);
			6'd10: w = mk(OP_ANG,    8'd3,  1'b1, 1'b1, 1'b0);
			6'd11: w = mk(OP_ANG,    8'd2,  1'b1, 1'b1, 1'b0);
			6'd12: w = mk(OP_ANG,    8'd1,  1'b1, 1'b1, 1'b0);
			6'd13: w = mk(OP_ANG,    8'd0,  1'b1, 1'b0, 1'b0);
			6'd14: w = mk(OP_CONST,  ",",   1'b1, 1'b0, 1'b0);
			6'd15: w = mk(OP_CONST,  "R",   1'b1, 1'b0, 1'b0);
			6'd16: w = mk(OP_CONST,  ",",   1'b1, 1'b0, 1'b0);
			6'd17: w = mk(OP_SPD,    8'd3,  1'b1, 1'b1, 1'b0);
			6'd18: w = mk(OP_SPD,    8'd2,  1'b1, 1'b1, 1'b0);
			6'd19: w = mk(OP_SPD,    8'd1,  1'b1, 1'b0, 1'b0);
			6'd20: w = mk(OP_CONST,  ".",   1'b1, 1'b0, 1'b0);
			6'd21: w = mk(OP_SPD,    8'd0,  1'b1, 1'b0, 1'b0);
			6'd22: w = mk(OP_CONST,  ",",   1'b1, 1'b0, 1'b0);
			6'd23: w = mk(OP_CONST,  "N",   1'b1, 1'b0, 1'b0);
			6'd24: w = mk(OP_CONST,  ",",   1'b1, 1'b0, 1'b0);
			6'd25: w = mk(OP_CONST,  "A",   1'b1, 1'b0, 1'b0);
			6'd26: w = mk(OP_CONST,  "*",   1'b0, 1'b0, 1'b0);
			6'd27: w = mk(OP_SUM_HI, 8'h00, 1'b0, 1'b0, 1'b0);
			6'd28: w = mk(OP_SUM_LO, 8'h00, 1'b0, 1'b0, 1'b0);
			6'd29: w = mk(OP_CONST,  "<",   1'b0, 1'b0, 1'b0);
			6'd30: w = mk(OP_CONST,  "C",   1'b0, 1'b0, 1'b0);
			6'd31: w = mk(OP_CONST,  "R",   1'b0, 1'b0, 1'b0);
			6'd32: w = mk(OP_CONST,  ">",   1'b0, 1'b0, 1'b0);
			6'd33: w = mk(OP_CONST,  "<",   1'b0, 1'b0, 1'b0);
			6'd34: w = mk(OP_CONST,  "L",   1'b0, 1'b0, 1'b0);
			6'd35: w = mk(OP_CONST,  "F",   1'b0, 1'b0, 1'b0);
			6'd36: w = mk(OP_CONST,  ">",   1'b0, 1'b0, 1'b0);
			6'd37: w = mk(OP_CONST,  8'h0D, 1'b0, 1'b0, 1'b0);
			6'd38: w = mk(OP_CONST,  8'h0A, 1'b0, 1'b0, 1'b1);
			default: w = mk(OP_IDLE, 8'h00, 1'b0, 1'b0, 1'b0);
		endcase
		return w;
	endfunction

	// upper-case hex digit
	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] n);
		logic [CHAR_W-1:0] c;
		if (n < 4'd10) begin
			c = 8'h30 + {4'h0, n};
		end else begin
			c = 8'h37 + {4'h0, n};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== sv/stwmwv_word_if.sv =====
`default_nettype none
interface stwmwv_word_if import stwmwv_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] bus_word;

	modport source (output valid, output bus_word, input ready);
	modport sink (input valid, input bus_word, output ready);
endinterface
`default_nettype wire

// ===== sv/stwmwv_char_if.sv =====
`default_nettype none
interface stwmwv_char_if import stwmwv_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] out_char;
	logic              last_char;

	modport source (output valid, output out_char, output last_char, input ready);
	modport sink (input valid, input out_char, input last_char, output ready);
endinterface
`default_nettype wire

// ===== sv/seatalk_wind_to_nmea_mwv_core.sv =====
// SeaTalk wind datagrams in, NMEA MWV sentence characters out.
// bus: one 9-bit SeaTalk word per handshake; bit 8 marks a command word that
//   opens a four-word datagram (command, three data bytes).
// sentence: one ASCII character per word, last_char set on the closing LF.
// Command 0x10 updates the wind angle, 0x11 the speed; either one triggers a
// sentence of up to 37 characters. Other commands produce nothing.
// Control is a 39-step microprogram; bus words are taken only while it sits
// at its idle step. An updating word runs the binary to bcd conversion over
// all 15 input bits, then the 37 character steps, each a character or a
// dropped leading zero.
// The output register holds a character until it is taken; a stall on the
// sentence channel freezes the program at the next step that emits a character;
// dropped leading zeros still advance. Reset clears the datagram position, the
// stored angle and speed (both print as zero), and the output valid.
`default_nettype none
module seatalk_wind_to_nmea_mwv_core import stwmwv_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	stwmwv_word_if.sink   bus,
	stwmwv_char_if.source sentence
);

	// sequencer and datagram state
	logic [STEP_W-1:0] step_q;
	pos_t              pos_q;
	logic [BYTE_W-1:0] cmd_q;
	logic [BYTE_W-1:0] byte2_q;

	// stored values in bcd
	logic [ANG_DIGITS-1:0][3:0] ang_bcd_q;
	logic [SPD_DIGITS-1:0][3:0] spd_bcd_q;

	// converter datapath
	logic [BIN_W-1:0]           conv_bin_q;
	logic [ANG_DIGITS-1:0][3:0] conv_bcd_q;
	logic [CNT_W-1:0]           conv_cnt_q;
	logic                       conv_ang_q;
	logic [ANG_DIGITS-1:0][3:0] bcd_adj;
	logic [ANG_DIGITS*4:0]      bcd_shift;
	logic [ANG_DIGITS-1:0][3:0] bcd_next;
	logic [BIN_W-1:0]           bin_next;

	// character path
	logic [CHAR_W-1:0] sum_q;
	logic              lead_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_last_q;

	ucw_t              uc;
	logic [3:0]        dig_ang;
	logic [3:0]        dig_spd;
	logic [CHAR_W-1:0] ch;
	logic              is_char;
	logic              skip;
	logic              out_free;
	logic              emit;
	logic              adv;
	logic              bus_take;
	logic [BYTE_W-1:0] bus_byte;
	logic [BIN_W-1:0]  angle_val;
	logic [BIN_W-1:0]  speed_val;
	logic [BYTE_W-1:0] speed_hi;

	assign uc = ucode(step_q);

	// datagram values
	assign bus_byte = bus.bus_word[BYTE_W-1:0];
	assign angle_val = {byte2_q, bus_byte[BYTE_W-1:1]};
	assign speed_hi = byte2_q & SPEED_MASK;
	assign speed_val = ({{(BIN_W-BYTE_W){1'b0}}, speed_hi} << 3)
		+ ({{(BIN_W-BYTE_W){1'b0}}, speed_hi} << 1)
		+ {{(BIN_W-BYTE_W){1'b0}}, bus_byte};

	// one double-dabble iteration
	always_comb begin
		for (int i = 0; i < ANG_DIGITS; i++) begin
			bcd_adj[i] = (conv_bcd_q[i] >= 4'd5) ? conv_bcd_q[i] + 4'd3 : conv_bcd_q[i];
		end
		bcd_shift = {bcd_adj, conv_bin_q[BIN_W-1]};
		bcd_next = bcd_shift[ANG_DIGITS*4-1:0];
		bin_next = {conv_bin_q[BIN_W-2:0], 1'b0};
	end

	// character selection for the current step
	always_comb begin
		dig_ang = ang_bcd_q[uc.arg[2:0]];
		dig_spd = spd_bcd_q[uc.arg[1:0]];
		ch = '0;
		skip = 1'b0;
		is_char = 1'b1;
		unique case (uc.op)
			OP_CONST: begin
				ch = uc.arg;
			end
			OP_ANG: begin
				ch = {4'h3, dig_ang};
				skip = uc.lead && lead_q && (dig_ang == 4'd0);
			end
			OP_SPD: begin
				ch = {4'h3, dig_spd};
				skip = uc.lead && lead_q && (dig_spd == 4'd0);
			end
			OP_SUM_HI: begin
				ch = hex_char(sum_q[7:4]);
				skip = (sum_q[7:4] == 4'd0);
			end
			OP_SUM_LO: begin
				ch = hex_char(sum_q[3:0]);
			end
			default: begin
				is_char = 1'b0;
			end
		endcase
		out_free = !out_valid_q || sentence.ready;
		emit = is_char && !skip && out_free;
		adv = is_char && (skip || out_free);
	end

	assign bus.ready = (uc.op == OP_IDLE);
	assign bus_take = bus.valid && bus.ready;

	assign sentence.valid = out_valid_q;
	assign sentence.out_char = out_char_q;
	assign sentence.last_char = out_last_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			pos_q <= POS_IDLE;
			cmd_q <= '0;
			byte2_q <= '0;
			ang_bcd_q <= '0;
			spd_bcd_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// datagram parsing
			if (bus_take) begin
				if (bus.bus_word[WORD_W-1]) begin
					cmd_q <= bus_byte;
					pos_q <= POS_BYTE1;
				end else begin
					unique case (pos_q)
						POS_IDLE: begin
							pos_q <= POS_IDLE;
						end
						POS_BYTE1: begin
							pos_q <= POS_BYTE2;
						end
						POS_BYTE2: begin
							byte2_q <= bus_byte;
							pos_q <= POS_BYTE3;
						end
						default: begin
							pos_q <= POS_IDLE;
							if (cmd_q == CMD_ANGLE || cmd_q == CMD_SPEED) begin
								step_q <= STEP_W'(1);
							end
						end
					endcase
				end
			end

			// conversion loop, result into the selected store
			if (uc.op == OP_CONV && conv_cnt_q == CNT_W'(1)) begin
				step_q <= step_q + STEP_W'(1);
				if (conv_ang_q) begin
					ang_bcd_q <= bcd_next;
				end else begin
					spd_bcd_q <= bcd_next[SPD_DIGITS-1:0];
				end
			end

			// character steps
			if (adv) begin
				if (uc.last) begin
					step_q <= '0;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end

			// output register
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (sentence.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (bus_take && !bus.bus_word[WORD_W-1] && pos_q == POS_BYTE3) begin
			conv_ang_q <= (cmd_q == CMD_ANGLE);
			conv_bin_q <= (cmd_q == CMD_ANGLE) ? angle_val : speed_val;
			conv_bcd_q <= '0;
			conv_cnt_q <= CNT_W'(BIN_W);
			sum_q <= '0;
		end else if (uc.op == OP_CONV) begin
			conv_bin_q <= bin_next;
			conv_bcd_q <= bcd_next;
			conv_cnt_q <= conv_cnt_q - CNT_W'(1);
		end
		if (emit) begin
			out_char_q <= ch;
			out_last_q <= uc.last;
			lead_q <= (uc.op == OP_CONST);
			if (uc.sum_en) begin
				sum_q <= sum_q ^ ch;
			end
		end
	end

endmodule
`default_nettype wire

// ===== tb/stwmwv_mwv_checker.sv =====
`timescale 1ns / 100ps
module stwmwv_mwv_checker import stwmwv_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	stwmwv_word_if      bus,
	stwmwv_char_if      sentence,
	output int          errors,
	output int unsigned pending
);

	// one expected sentence character
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} mwv_char_t;

	mwv_char_t         nmea_chars_q[$];

	// shadow of the datagram decoder and the stored wind data
	pos_t              word_pos;
	logic [BYTE_W-1:0] dgram_bytes [3];
	logic [14:0]       wind_angle_q;
	logic [10:0]       speed_tenths;
	logic [7:0]        run_sum;

	// queue one character, folding it into the checksum when asked
	function automatic void emit(input logic [CHAR_W-1:0] c, input logic summed,
		input logic last);
		mwv_char_t e;
		e.ch = c;
		e.last = last;
		nmea_chars_q.push_back(e);
		if (summed) begin
			run_sum = run_sum ^ c;
		end
	endfunction

	function automatic void emit_text(input string s, input logic summed);
		for (int i = 0; i < s.len(); i++) begin
			emit(s[i], summed, 1'b0);
		end
	endfunction

	// unpadded decimal, most significant digit first
	function automatic void emit_dec(input int unsigned v);
		logic [7:0]  digs [5];
		int          k;
		int unsigned r;
		k = 0;
		r = v;
		do begin
			digs[k] = 8'h30 + 8'(r % 10);
			k++;
			r = r / 10;
		end while (r != 0 && k < 5);
		while (k > 0) begin
			k--;
			emit(digs[k], 1'b1, 1'b0);
		end
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h41 + 8'(n) - 8'd10);
	endfunction

	// whole mwv sentence from the stored angle and speed
	function automatic void emit_sentence();
		run_sum = 8'h00;
		emit("$", 1'b0, 1'b0);
		emit_text("WIMWV,", 1'b1);
		emit_dec(int'(wind_angle_q));
		emit_text(",R,", 1'b1);
		emit_dec(int'(speed_tenths) / 10);
		emit(".", 1'b1, 1'b0);
		emit_dec(int'(speed_tenths) % 10);
		emit_text(",N,A", 1'b1);
		emit("*", 1'b0, 1'b0);
		// checksum in hex, no leading zero
		if (run_sum >= 8'd16) begin
			emit(hex_digit(run_sum[7:4]), 1'b0, 1'b0);
		end
		emit(hex_digit(run_sum[3:0]), 1'b0, 1'b0);
		emit_text("<CR><LF>", 1'b0);
		emit(8'h0D, 1'b0, 1'b0);
		emit(8'h0A, 1'b0, 1'b1);
	endfunction

	// advance the decoder by one bus word
	function automatic void take_word(input logic [WORD_W-1:0] w);
		logic [BYTE_W-1:0] b;
		logic [15:0]       raw;
		int unsigned       t;
		b = w[7:0];
		if (w[8]) begin
			// a command word always opens a fresh datagram
			dgram_bytes[0] = b;
			word_pos = POS_BYTE1;
		end else if (word_pos == POS_IDLE) begin
			// stray data word, dropped
		end else if (word_pos != POS_BYTE3) begin
			dgram_bytes[int'(word_pos)] = b;
			word_pos = pos_t'(word_pos + 2'd1);
		end else begin
			word_pos = POS_IDLE;
			if (dgram_bytes[0] == CMD_ANGLE) begin
				raw = {dgram_bytes[2], b};
				wind_angle_q = raw[15:1];
				emit_sentence();
			end else if (dgram_bytes[0] == CMD_SPEED) begin
				t = int'(dgram_bytes[2] & SPEED_MASK) * 10 + int'(b);
				speed_tenths = 11'(t);
				emit_sentence();
			end
		end
	endfunction

	// compare each taken character, then feed each taken bus word
	always @(posedge clk or negedge arst_n) begin
		int        tally;
		mwv_char_t want;
		if (!arst_n) begin
			word_pos = POS_IDLE;
			dgram_bytes[0] = '0;
			dgram_bytes[1] = '0;
			dgram_bytes[2] = '0;
			wind_angle_q = '0;
			speed_tenths = '0;
			run_sum = '0;
			nmea_chars_q.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			tally = 0;
			if (sentence.valid && sentence.ready) begin
				if (nmea_chars_q.size() == 0) begin
					$error("out_char: expected none, got %h (last_char %b)",
						sentence.out_char, sentence.last_char);
					tally++;
				end else begin
					want = nmea_chars_q.pop_front();
					if (sentence.out_char !== want.ch) begin
						$error("out_char: expected %h, got %h", want.ch, sentence.out_char);
						tally++;
					end
					if (sentence.last_char !== want.last) begin
						$error("last_char: expected %b, got %b", want.last,
							sentence.last_char);
						tally++;
					end
				end
			end
			if (bus.valid && bus.ready) begin
				take_word(bus.bus_word);
			end
			errors <= errors + tally;
			pending <= nmea_chars_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top import stwmwv_pkg::*; ();

	// a command code that is neither angle nor speed
	localparam logic [BYTE_W-1:0] CMD_OTHER = 8'h5A;
	localparam int RX_HOLD_CYCLES = 600;
	localparam int RX_HOLD_AFTER = 200;

	logic        clk;
	logic        arst_n;
	int          errors;
	int unsigned pending;
	bit          tx_quiet;
	bit          rx_quiet;
	bit          rx_held;
	int          chars_taken;

	stwmwv_word_if bus_if ();
	stwmwv_char_if nmea_if ();

	seatalk_wind_to_nmea_mwv_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.bus      (bus_if),
		.sentence (nmea_if)
	);

	stwmwv_mwv_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.bus      (bus_if),
		.sentence (nmea_if),
		.errors   (errors),
		.pending  (pending)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// offer one bus word after a random gap, return at the falling edge after it is taken
	task automatic send_word(input logic [WORD_W-1:0] w);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			bus_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		bus_if.valid <= 1'b1;
		bus_if.bus_word <= w;
		do @(posedge clk); while (!(bus_if.valid && bus_if.ready));
		@(negedge clk);
	endtask

	task automatic send_datagram(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] b1,
		input logic [BYTE_W-1:0] b2, input logic [BYTE_W-1:0] b3);
		send_word({1'b1, cmd});
		send_word({1'b0, b1});
		send_word({1'b0, b2});
		send_word({1'b0, b3});
	endtask

	// reset, then directed and random bus words, then the verdict
	initial begin
		int                kind;
		int                waited;
		logic [BYTE_W-1:0] cmd;
		logic [BYTE_W-1:0] b1;
		logic [BYTE_W-1:0] b2;
		logic [BYTE_W-1:0] b3;
		arst_n = 1'b0;
		bus_if.valid = 1'b0;
		bus_if.bus_word = '0;
		tx_quiet = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// data words while idle are dropped
		send_word({1'b0, 8'h55});
		send_word({1'b0, 8'hFF});
		// unknown command before any update
		send_datagram(CMD_OTHER, 8'h00, 8'h12, 8'h34);
		// largest angle, then largest speed with the top bit masked
		send_datagram(CMD_ANGLE, 8'hAA, 8'hFF, 8'hFF);
		send_datagram(CMD_SPEED, 8'h00, 8'hFF, 8'hFF);
		// zero angle and zero speed
		send_datagram(CMD_ANGLE, 8'h00, 8'h00, 8'h01);
		send_datagram(CMD_SPEED, 8'h55, 8'h80, 8'h00);
		// command word inside a datagram restarts it
		send_word({1'b1, CMD_ANGLE});
		send_word({1'b0, 8'h12});
		send_datagram(CMD_SPEED, 8'h01, 8'h02, 8'h03);

		// mostly well-formed datagrams, some noise and broken ones
		for (int s = 0; s < 100; s++) begin
			if ($urandom_range(0, 7) == 0) begin
				tx_quiet = ~tx_quiet;
			end
			kind = $urandom_range(0, 19);
			b1 = 8'($urandom);
			b2 = 8'($urandom);
			b3 = 8'($urandom);
			if (kind < 8) begin
				if ($urandom_range(0, 3) == 0) begin
					b2 = 8'h00;
					b3 = 8'($urandom_range(0, 40));
				end
				send_datagram(CMD_ANGLE, b1, b2, b3);
			end else if (kind < 16) begin
				if ($urandom_range(0, 3) == 0) begin
					b2 = {b2[7], 7'($urandom_range(0, 1))};
					b3 = 8'($urandom_range(0, 15));
				end
				send_datagram(CMD_SPEED, b1, b2, b3);
			end else if (kind == 16) begin
				do cmd = 8'($urandom); while (cmd == CMD_ANGLE || cmd == CMD_SPEED);
				send_datagram(cmd, b1, b2, b3);
			end else if (kind == 17) begin
				send_word({1'b0, b1});
			end else begin
				// partial datagram, left for the next command word to abandon
				cmd = ($urandom_range(0, 1) == 0) ? CMD_ANGLE : CMD_SPEED;
				send_word({1'b1, cmd});
				repeat ($urandom_range(0, 2)) send_word({1'b0, 8'($urandom)});
			end
		end
		bus_if.valid <= 1'b0;

		// drain the sentence channel
		waited = 0;
		while (pending != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

	// sentence receiver: random stalls, quiet stretches, one long hold-off
	initial begin
		int stall;
		nmea_if.ready = 1'b0;
		rx_quiet = 1'b0;
		rx_held = 1'b0;
		chars_taken = 0;
		@(negedge clk);
		forever begin
			if (!rx_held && chars_taken >= RX_HOLD_AFTER) begin
				rx_held = 1'b1;
				nmea_if.ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
			end
			stall = rx_quiet ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				nmea_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			nmea_if.ready <= 1'b1;
			do @(posedge clk); while (!(nmea_if.valid && nmea_if.ready));
			chars_taken++;
			if ($urandom_range(0, 31) == 0) begin
				rx_quiet = ~rx_quiet;
			end
			@(negedge clk);
		end
	end

	// run limit
	initial begin
		#8000000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
